[design/stable_priority_queue_top_assert.svh]
// ----------------------------------------------------------------------------
// stable priority queue assertion macros
// shared property forms for the queue's concurrent checks
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_TOP_ASSERT_SVH

// same-cycle implication under reset
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("queue check failed");

// next-cycle implication under reset
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("queue check failed");

`endif

[design/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// sizes, status codes and shared types of the stable priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH       = 16;
    localparam int PRIO_BITS   = 8;
    localparam int TAG_BITS    = 16;
    localparam int OCC_BITS    = $clog2(DEPTH + 1);
    localparam int S_DATA_BITS = ((PRIO_BITS + TAG_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = ((PRIO_BITS + TAG_BITS + OCC_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_REMOVE = 1'b1
    } mode_t;

    typedef struct packed {
        logic                 used;
        logic [PRIO_BITS-1:0] prio;
        logic [TAG_BITS-1:0]  tag;
    } slot_t;

    typedef struct packed {
        logic                 ins;
        logic                 rem;
        logic [PRIO_BITS-1:0] prio;
        logic [TAG_BITS-1:0]  tag;
    } ctrl_t;

endpackage

[design/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain; takes the new item, its left or right neighbour
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  spq_pkg::ctrl_t ctrl,
    input  spq_pkg::slot_t prev_slot,
    input  logic          prev_take,
    input  spq_pkg::slot_t next_slot,
    output spq_pkg::slot_t slot,
    output logic          take
);
    import spq_pkg::*;

    logic                 used_reg;
    logic                 used_next;
    logic [PRIO_BITS-1:0] prio_reg;
    logic [PRIO_BITS-1:0] prio_next;
    logic [TAG_BITS-1:0]  tag_reg;
    logic [TAG_BITS-1:0]  tag_next;

    // slot lies behind the insert point
    assign take = !used_reg || (prio_reg > ctrl.prio);
    assign slot = '{used: used_reg, prio: prio_reg, tag: tag_reg};

    always_comb
    begin
        used_next = used_reg;
        prio_next = prio_reg;
        tag_next  = tag_reg;
        priority if (ctrl.rem)
        begin
            used_next = next_slot.used;
            prio_next = next_slot.prio;
            tag_next  = next_slot.tag;
        end
        else if (ctrl.ins && take && !prev_take)
        begin
            used_next = 1'b1;
            prio_next = ctrl.prio;
            tag_next  = ctrl.tag;
        end
        else if (ctrl.ins && take)
        begin
            used_next = prev_slot.used;
            prio_next = prev_slot.prio;
            tag_next  = prev_slot.tag;
        end
        else
        begin
            used_next = used_reg;
            prio_next = prio_reg;
            tag_next  = tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        tag_reg  <= tag_next;
    end

endmodule

[design/stable_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// bounded priority queue held sorted in a chain of slot cells
// ----------------------------------------------------------------------------
// s_* carries one operation per item: s_tuser selects insert or remove, and
// s_tdata holds the priority and tag of an entry to insert. lower priority
// values leave first, equal priorities leave in arrival order.
// m_* returns exactly one item per operation: status in m_tuser, and in
// m_tdata the removed entry (zero otherwise) and the occupancy afterwards.
// every slot compares against the new priority at once and shifts to its
// neighbour in the same cycle, so an item is taken every cycle unless the
// output stalls, and its result is registered in the cycle after acceptance.
// the result register frees up when m_tready is high, so s_tready follows
// m_tready while a result is pending; a stalled receiver stalls the input.
// an insert into a full queue is dropped with status full; a remove on an
// empty queue reports status empty. reset empties the queue at once.
// ----------------------------------------------------------------------------
module stable_priority_queue_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [spq_pkg::S_DATA_BITS-1:0] s_tdata,  // priority_req, tag
    input  logic                            s_tuser,  // mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [spq_pkg::M_DATA_BITS-1:0] m_tdata,  // out_priority, out_tag, occupancy
    output logic [1:0]                      m_tuser   // status
);
    import spq_pkg::*;

    logic                 s_fire;
    logic                 is_remove;
    logic                 full;
    logic                 empty;
    ctrl_t                ctrl;
    slot_t                slots [DEPTH];
    logic                 takes [DEPTH];
    logic [DEPTH-1:0]     used_vec;

    logic [OCC_BITS-1:0]  count_reg;
    logic [OCC_BITS-1:0]  count_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    status_t              status_reg;
    status_t              status_next;
    logic [PRIO_BITS-1:0] out_prio_reg;
    logic [PRIO_BITS-1:0] out_prio_next;
    logic [TAG_BITS-1:0]  out_tag_reg;
    logic [TAG_BITS-1:0]  out_tag_next;
    logic [OCC_BITS-1:0]  occ_reg;

    assign s_tready  = !out_valid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign is_remove = (s_tuser == MODE_REMOVE);
    assign full      = (count_reg == OCC_BITS'(DEPTH));
    assign empty     = (count_reg == '0);

    assign ctrl.ins  = s_fire && !is_remove && !full;
    assign ctrl.rem  = s_fire && is_remove && !empty;
    assign ctrl.prio = s_tdata[PRIO_BITS-1:0];
    assign ctrl.tag  = s_tdata[PRIO_BITS +: TAG_BITS];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        slot_t prev_s;
        slot_t next_s;
        logic  prev_t;

        if (i == 0)
        begin : g_first
            assign prev_s = '0;
            assign prev_t = 1'b0;
        end
        else
        begin : g_mid
            assign prev_s = slots[i-1];
            assign prev_t = takes[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_s = '0;
        end
        else
        begin : g_inner
            assign next_s = slots[i+1];
        end

        spq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .prev_slot (prev_s),
            .prev_take (prev_t),
            .next_slot (next_s),
            .slot      (slots[i]),
            .take      (takes[i])
        );

        assign used_vec[i] = slots[i].used;
    end

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        out_prio_next  = out_prio_reg;
        out_tag_next   = out_tag_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (s_fire)
        begin
            out_valid_next = 1'b1;
            out_prio_next  = '0;
            out_tag_next   = '0;
            priority if (ctrl.rem)
            begin
                status_next   = ST_REMOVED;
                out_prio_next = slots[0].prio;
                out_tag_next  = slots[0].tag;
                count_next    = count_reg - 1'b1;
            end
            else if (ctrl.ins)
            begin
                status_next = ST_INSERTED;
                count_next  = count_reg + 1'b1;
            end
            else if (is_remove)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                status_next = ST_FULL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            status_reg   <= status_next;
            out_prio_reg <= out_prio_next;
            out_tag_reg  <= out_tag_next;
            occ_reg      <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = M_DATA_BITS'({occ_reg, out_tag_reg, out_prio_reg});

`include "stable_priority_queue_top_assert.svh"

    `SPQ_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, count_reg <= OCC_BITS'(DEPTH))
    `SPQ_ASSERT_NOW(a_used_count, clk, rst_n, 1'b1, $countones(used_vec) == int'(count_reg))
    `SPQ_ASSERT_NOW(a_head_order, clk, rst_n, slots[1].used, slots[0].prio <= slots[1].prio)
    `SPQ_ASSERT_NEXT(a_insert_grows, clk, rst_n, ctrl.ins, count_reg == $past(count_reg) + 1'b1)

endmodule

[test/stable_priority_queue_top_test.sv]
// ----------------------------------------------------------------------------
// stable_priority_queue_top_test
// self-checking bench for the stable priority queue: a directed opening
// covers empty removes, equal priorities, extreme values and a full queue,
// then random runs of insert-heavy, balanced and drain-heavy traffic follow.
// a local sorted-slot model predicts every result, and both stream sides
// idle in random bursts until the final stretch.
// ----------------------------------------------------------------------------
module stable_priority_queue_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int TAIL_ITEMS   = 150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        mode_t                mode;
        logic [PRIO_BITS-1:0] prio;
        logic [TAG_BITS-1:0]  tag;
    } queue_op_t;

    typedef struct {
        status_t              status;
        logic [PRIO_BITS-1:0] prio;
        logic [TAG_BITS-1:0]  tag;
        logic [OCC_BITS-1:0]  occ;
    } queue_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_BITS-1:0] m_tdata;
    logic [1:0]             m_tuser;

    queue_op_t     pending_ops[$];
    queue_result_t awaited_results[$];

    logic [PRIO_BITS-1:0] model_prio[DEPTH];
    logic [TAG_BITS-1:0]  model_tag[DEPTH];
    int                   model_count;

    int   error_count;
    int   cycle_count;
    logic in_taken;
    int   send_gap;
    int   recv_stall;
    logic send_calm;
    logic recv_calm;

    stable_priority_queue_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic queue_result_t queue_apply(input queue_op_t op);
        queue_result_t r;
        int            pos;
        r.status = ST_INSERTED;
        r.prio   = '0;
        r.tag    = '0;
        if (op.mode == MODE_INSERT)
        begin
            if (model_count >= DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                pos = model_count;
                for (int i = 0; i < model_count; i++)
                begin
                    if (pos == model_count && model_prio[i] > op.prio)
                        pos = i;
                end
                for (int i = model_count; i > pos; i--)
                begin
                    model_prio[i] = model_prio[i-1];
                    model_tag[i]  = model_tag[i-1];
                end
                model_prio[pos] = op.prio;
                model_tag[pos]  = op.tag;
                model_count++;
            end
        end
        else if (model_count == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            r.status = ST_REMOVED;
            r.prio   = model_prio[0];
            r.tag    = model_tag[0];
            for (int i = 0; i + 1 < model_count; i++)
            begin
                model_prio[i] = model_prio[i+1];
                model_tag[i]  = model_tag[i+1];
            end
            model_count--;
        end
        r.occ = OCC_BITS'(model_count);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        if (error_count < 40)
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
        error_count++;
    endtask

    task automatic queue_op(input mode_t mode, input logic [PRIO_BITS-1:0] prio,
                            input logic [TAG_BITS-1:0] tag);
        queue_op_t op;
        op.mode = mode;
        op.prio = prio;
        op.tag  = tag;
        pending_ops.push_back(op);
    endtask

    // driver: holds an item until taken, otherwise idles or sends the next one
    always @(negedge clk)
    begin
        queue_op_t              op;
        logic [S_DATA_BITS-1:0] word;
        if (rst_n)
        begin
            if ($urandom_range(0, 63) == 0)
                send_calm = !send_calm;
            if (s_tvalid && !in_taken)
            begin
                s_tvalid <= 1'b1;
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_ops.size() == 0)
            begin
                s_tvalid <= 1'b0;
            end
            else if (!send_calm && pending_ops.size() > TAIL_ITEMS
                     && $urandom_range(0, 4) == 0)
            begin
                send_gap = $urandom_range(1, 5) - 1;
                s_tvalid <= 1'b0;
            end
            else
            begin
                op   = pending_ops.pop_front();
                word = '0;
                word[PRIO_BITS-1:0]       = op.prio;
                word[PRIO_BITS +: TAG_BITS] = op.tag;
                s_tvalid <= 1'b1;
                s_tdata  <= word;
                s_tuser  <= op.mode;
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(0, 63) == 0)
                recv_calm = !recv_calm;
            if (recv_calm || pending_ops.size() <= TAIL_ITEMS)
            begin
                m_tready <= 1'b1;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                recv_stall = $urandom_range(1, 5) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor: check results against the model, then predict accepted items
    always @(posedge clk)
    begin
        queue_op_t     op;
        queue_result_t want;
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("stable_priority_queue_top_test: done, errors");
                $finish;
            end
            else
            begin
                if (m_tvalid && m_tready)
                begin
                    if (awaited_results.size() == 0)
                    begin
                        report_mismatch("unexpected item", 32'd0, m_tdata);
                    end
                    else
                    begin
                        want = awaited_results.pop_front();
                        if (m_tuser !== want.status)
                            report_mismatch("status", 32'(want.status), 32'(m_tuser));
                        if (m_tdata[PRIO_BITS-1:0] !== want.prio)
                            report_mismatch("out_priority", 32'(want.prio),
                                            32'(m_tdata[PRIO_BITS-1:0]));
                        if (m_tdata[PRIO_BITS +: TAG_BITS] !== want.tag)
                            report_mismatch("out_tag", 32'(want.tag),
                                            32'(m_tdata[PRIO_BITS +: TAG_BITS]));
                        if (m_tdata[PRIO_BITS+TAG_BITS +: OCC_BITS] !== want.occ)
                            report_mismatch("occupancy", 32'(want.occ),
                                            32'(m_tdata[PRIO_BITS+TAG_BITS +: OCC_BITS]));
                    end
                end
                in_taken = s_tvalid && s_tready;
                if (in_taken)
                begin
                    op.mode = mode_t'(s_tuser);
                    op.prio = s_tdata[PRIO_BITS-1:0];
                    op.tag  = s_tdata[PRIO_BITS +: TAG_BITS];
                    awaited_results.push_back(queue_apply(op));
                end
            end
        end
    end

    initial
    begin
        int                   count;
        int                   span;
        int                   insert_pct;
        logic                 narrow;
        logic [PRIO_BITS-1:0] base;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = MODE_INSERT;
        m_tready    = 1'b0;
        rst_n       = 1'b0;
        in_taken    = 1'b0;
        send_gap    = 0;
        recv_stall  = 0;
        send_calm   = 1'b0;
        recv_calm   = 1'b0;
        error_count = 0;
        cycle_count = 0;
        model_count = 0;

        // remove on empty, equal priorities, extremes, then fill past full
        queue_op(MODE_REMOVE, 8'hFF, 16'hFFFF);
        queue_op(MODE_INSERT, 8'd5, 16'h1111);
        queue_op(MODE_INSERT, 8'd5, 16'h2222);
        queue_op(MODE_INSERT, 8'd0, 16'h0000);
        queue_op(MODE_INSERT, 8'hFF, 16'hFFFF);
        queue_op(MODE_INSERT, 8'd5, 16'h3333);
        queue_op(MODE_INSERT, 8'hFF, 16'h0001);
        queue_op(MODE_REMOVE, 8'd0, 16'h0000);
        queue_op(MODE_REMOVE, 8'd0, 16'h0000);
        for (int i = 0; i < 12; i++)
            queue_op(MODE_INSERT, PRIO_BITS'(i * 23), TAG_BITS'(16'hA000 + i));
        queue_op(MODE_INSERT, 8'd1, 16'h5A5A);
        queue_op(MODE_REMOVE, 8'hAA, 16'h5555);

        // random runs that swing between filling and draining
        count = 0;
        while (count < RANDOM_ITEMS)
        begin
            span       = $urandom_range(10, 60);
            insert_pct = ($urandom_range(0, 2) == 0) ? 25 :
                         ($urandom_range(0, 1) == 0) ? 50 : 85;
            narrow     = 1'($urandom_range(0, 1));
            base       = PRIO_BITS'($urandom);
            for (int k = 0; k < span; k++)
            begin
                queue_op(mode_t'(($urandom_range(0, 99) < insert_pct) ? MODE_INSERT
                                                                        : MODE_REMOVE),
                         narrow ? {base[PRIO_BITS-1:2], 2'($urandom)} : PRIO_BITS'($urandom),
                         TAG_BITS'($urandom));
            end
            count += span;
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_ops.size() != 0 || s_tvalid)
            @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("stable_priority_queue_top_test: done, clean");
        else
            $display("stable_priority_queue_top_test: done, errors");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/spq_pkg.sv
design/spq_cell.sv
design/stable_priority_queue_top.sv
test/stable_priority_queue_top_test.sv
